>>> hw/rtl/voap_pkg.sv
package voap_pkg;

    localparam int unsigned CFG_W          = 31;
    localparam logic [30:0] HW_RESET       = 31'd20971520;
    localparam logic [30:0] HH_RESET       = 31'd6553600;
    localparam int unsigned DIV_STAGES     = 16;
    localparam int unsigned FIFO_DEPTH_DEF = 32;

    localparam logic REG_HALF_WIDTH  = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;

    typedef struct packed {
        logic [4:0]         clip_codes;
        logic               projected;
        logic               overflow;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } result_t;

    typedef struct packed {
        logic [4:0]         codes;
        logic signed [62:0] prod_x;
        logic signed [62:0] prod_y;
        logic signed [31:0] z;
    } front_t;

    // rem holds the partial remainder, sh the dividend bits still to shift in
    // (top) and the quotient bits gathered so far (bottom)
    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] sh;
    } div_state_t;

    // Two restoring division steps
    function automatic div_state_t div_step2(div_state_t s, logic [30:0] d);
        logic [31:0] t;
        div_state_t  r;
        r = s;
        for (int i = 0; i < 2; i++) begin
            t    = {r.rem, r.sh[31]};
            r.sh = {r.sh[30:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t       = t - {1'b0, d};
                r.sh[0] = 1'b1;
            end
            r.rem = t[30:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/voap_front.sv
module voap_front
    import voap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [30:0]        half_width,
    input  logic [30:0]        half_height,
    output logic               valid,
    output front_t             data
);

    logic               valid_reg;
    front_t             data_reg;
    front_t             data_next;
    logic signed [32:0] x33;
    logic signed [32:0] y33;
    logic signed [32:0] z33;
    logic signed [32:0] nz33;
    logic signed [63:0] px;
    logic signed [63:0] py;

    always_comb
    begin
        x33  = {point_x[31], point_x};
        y33  = {point_y[31], point_y};
        z33  = {point_z[31], point_z};
        nz33 = -z33;
        px   = 64'(point_x) * 64'($signed({1'b0, half_width}));
        py   = 64'(point_y) * 64'($signed({1'b0, half_height}));
        data_next.codes  = {point_z[31], (y33 < nz33), (x33 < nz33),
                            (y33 > z33), (x33 > z33)};
        data_next.prod_x = px[62:0];
        data_next.prod_y = py[62:0];
        data_next.z      = point_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> hw/rtl/voap_div.sv
module voap_div
    import voap_pkg::*;
(
    input  logic               clk,
    input  logic signed [62:0] prod,
    input  logic signed [31:0] den,
    output logic [31:0]        quot,
    output logic               neg,
    output logic               bad
);

    div_state_t         st_reg  [0:DIV_STAGES];
    logic [30:0]        d_reg   [0:DIV_STAGES];
    logic               neg_reg [0:DIV_STAGES];
    logic               bad_reg [0:DIV_STAGES];
    logic [62:0]        mag;
    div_state_t         st0_next;

    always_comb
    begin
        mag = prod[62] ? 63'(-prod) : 63'(prod);
        st0_next.rem = {1'b0, mag[61:32]};
        st0_next.sh  = mag[31:0];
    end

    // Quotient of 2^32 or more, or a non-positive divisor, cannot be in range
    always_ff @(posedge clk)
    begin
        st_reg[0]  <= st0_next;
        d_reg[0]   <= den[30:0];
        neg_reg[0] <= prod[62];
        bad_reg[0] <= den[31] | ({1'b0, mag[61:32]} >= den[30:0]);
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        always_ff @(posedge clk)
        begin
            st_reg[g+1]  <= div_step2(st_reg[g], d_reg[g]);
            d_reg[g+1]   <= d_reg[g];
            neg_reg[g+1] <= neg_reg[g];
            bad_reg[g+1] <= bad_reg[g];
        end
    end

    assign quot = st_reg[DIV_STAGES].sh;
    assign neg  = neg_reg[DIV_STAGES];
    assign bad  = bad_reg[DIV_STAGES];

endmodule

>>> hw/rtl/voap_back.sv
module voap_back
    import voap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  front_t      in_data,
    input  logic [30:0] half_width,
    input  logic [30:0] half_height,
    output logic        out_valid,
    output result_t     out_data
);

    localparam int unsigned LAT = DIV_STAGES + 1;

    logic        vld_reg   [0:LAT-1];
    logic [4:0]  codes_reg [0:LAT-1];
    logic [31:0] qx;
    logic [31:0] qy;
    logic        negx;
    logic        negy;
    logic        badx;
    logic        bady;
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    logic signed [33:0] ax;
    logic signed [33:0] ay;
    logic        ok;
    result_t     res_next;
    result_t     res_reg;
    logic        out_valid_reg;

    voap_div u_div_x (
        .clk  (clk),
        .prod (in_data.prod_x),
        .den  (in_data.z),
        .quot (qx),
        .neg  (negx),
        .bad  (badx)
    );

    voap_div u_div_y (
        .clk  (clk),
        .prod (in_data.prod_y),
        .den  (in_data.z),
        .quot (qy),
        .neg  (negy),
        .bad  (bady)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg[0] <= in_data.codes;
        for (int i = 1; i < LAT; i++)
        begin
            codes_reg[i] <= codes_reg[i-1];
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        tx = negx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
        ty = negy ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
        ax = $signed({3'b000, half_width}) + tx;
        ay = $signed({3'b000, half_height}) - ty;
        ok = !codes_reg[LAT-1][4] && !badx && !bady
             && (negx ? (qx <= 32'h8000_0000) : !qx[31])
             && (negy ? (qy <= 32'h8000_0000) : !qy[31])
             && (ax[33:31] == 3'b000 || ax[33:31] == 3'b111)
             && (ay[33:31] == 3'b000 || ay[33:31] == 3'b111);
        res_next.clip_codes = codes_reg[LAT-1];
        res_next.projected  = ok;
        res_next.overflow   = !codes_reg[LAT-1][4] && !ok;
        res_next.screen_x   = ok ? ax[31:0] : 32'sd0;
        res_next.screen_y   = ok ? ay[31:0] : 32'sd0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

endmodule

>>> hw/rtl/voap_fifo.sv
module voap_fifo
    import voap_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wr_data,
    input  logic    rd,
    output result_t rd_data,
    output logic    empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t        mem [0:DEPTH-1];
    result_t        head_reg;
    logic           head_vld_reg;
    logic [AW-1:0]  wptr_reg;
    logic [AW-1:0]  rptr_reg;
    logic [CW-1:0]  count_reg;
    logic           load;

    // Refill the head register when the memory holds an entry and the head is free or being taken
    assign load = (count_reg != '0) && (!head_vld_reg || rd);

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
        if (load)
        begin
            head_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
            head_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (load)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr && !load)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (load && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (load)
            begin
                head_vld_reg <= 1'b1;
            end
            else if (rd)
            begin
                head_vld_reg <= 1'b0;
            end
        end
    end

    assign rd_data = head_reg;
    assign empty   = !head_vld_reg;

endmodule

>>> hw/rtl/vertex_outcode_and_project.sv
// Clip outcodes and perspective projection of camera-space points, 16.16 fixed
// point. One point is accepted per clock while full is low; its result passes
// through the classify/multiply stage, the divider setup stage, the 16-stage
// pipelined divider (two quotient bits per stage), the range stage and the
// result queue (memory write, then head register) before it can be popped.
// Up to FIFO_DEPTH points may be outstanding (accepted and not yet popped);
// full rises when that many are. With the default depth of 32 the block keeps
// one point per clock as long as results are popped as they come.
// half_width sits at address 0, half_height at 4; write them only while idle.
module vertex_outcode_and_project
    import voap_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               empty,
    input  logic               pop,
    output logic [4:0]         clip_codes,
    output logic               projected,
    output logic               overflow,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y
);

    localparam int unsigned CRW = $clog2(FIFO_DEPTH + 1);

    logic [30:0]    half_width_reg;
    logic [30:0]    half_height_reg;
    logic [CRW-1:0] credit_reg;
    logic           in_xfer;
    logic           out_xfer;
    logic           cfg_wr;
    logic           front_valid;
    front_t         front_data;
    logic           back_valid;
    result_t        back_data;
    result_t        head;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;
    assign full     = (credit_reg == CRW'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= HW_RESET;
            half_height_reg <= HH_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_HALF_WIDTH)
            begin
                half_width_reg <= pwdata[30:0];
            end
            else
            begin
                half_height_reg <= pwdata[30:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HALF_WIDTH:  prdata = {1'b0, half_width_reg};
            REG_HALF_HEIGHT: prdata = {1'b0, half_height_reg};
            default:         prdata = '0;
        endcase
    end

    // Count points in flight or waiting so the result queue never overflows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            credit_reg <= credit_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            credit_reg <= credit_reg - 1'b1;
        end
    end

    voap_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_xfer),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .valid       (front_valid),
        .data        (front_data)
    );

    voap_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (front_valid),
        .in_data     (front_data),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .out_valid   (back_valid),
        .out_data    (back_data)
    );

    voap_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (back_valid),
        .wr_data (back_data),
        .rd      (out_xfer),
        .rd_data (head),
        .empty   (empty)
    );

    assign clip_codes = head.clip_codes;
    assign projected  = head.projected;
    assign overflow   = head.overflow;
    assign screen_x   = head.screen_x;
    assign screen_y   = head.screen_y;

endmodule
